// File: rtl/core/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
  localparam int MAX_BLOCKS   = 32;
  localparam int HEADER_BYTES = 9;
  localparam int SPLIT_MIN    = 4;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic       CFG_HEAP_BASE  = 1'b0;
  localparam logic       CFG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_size;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_address;
  } out_item_t;
endpackage
`default_nettype wire

// File: rtl/core/first_fit_heap_allocator.sv
`default_nettype none
// First-fit heap allocator. One command (allocate or free) is taken when start
// is high and busy low; busy then stays high while a sequencer walks the block
// table one entry a cycle, with a running offset register building block
// offsets. An allocate walks to the first free entry that fits and, on a
// split, shifts the later entries up one slot and inserts the remainder. A
// free walks to the entry whose payload address matches, then for each
// following free neighbor merges it in and shifts the table down one slot.
// The single result shows on out_* with out_valid for exactly one cycle and
// cannot be stalled. A write to heap_bytes resets the table to one free block;
// config writes are taken only while idle (cfg_ready = !busy).
module first_fit_heap_allocator (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ffha_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ffha_pkg::out_item_t  out_item,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [0:0]           cfg_index,
  input  wire  [31:0]          cfg_data
);
  import ffha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SPLIT = 6'b000100,
    S_MCHK  = 6'b001000,
    S_MSHF  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // block table in flops; entries past count are never read
  logic        free_r [MAX_BLOCKS];
  logic [15:0] size_r [MAX_BLOCKS];
  logic [CNT_W-1:0] count_r;
  logic [31:0] base_r;

  logic        kind_r;
  logic [15:0] req_r;
  logic [31:0] addr_r;
  logic [IDX_W-1:0] i_r;   // walk pointer / target entry
  logic [IDX_W-1:0] k_r;   // shift pointer
  logic [31:0] off_r;      // running block offset
  out_item_t   res_r;
  logic        ov_r;

  logic [IDX_W-1:0] last_idx;
  logic [16:0] need, need_split;
  logic [31:0] pay_addr;
  logic        at_end, fits;
  // a walk that reaches the last slot without a match ends the command
  logic        scan_wrap;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = ov_r;
  assign out_item  = res_r;

  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign at_end     = (CNT_W'(i_r) >= count_r);
  assign need       = {1'b0, req_r} + 17'(HEADER_BYTES);
  assign need_split = need + 17'(SPLIT_MIN);
  assign pay_addr   = base_r + off_r + 32'(HEADER_BYTES);
  assign fits       = free_r[i_r] && ({1'b0, size_r[i_r]} >= need);
  assign scan_wrap  = (i_r == IDX_W'(MAX_BLOCKS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN;
      S_SCAN: begin
        if (at_end) state_nxt = S_DONE;
        else if (kind_r == KIND_ALLOC && fits) begin
          if ({1'b0, size_r[i_r]} >= need_split && count_r < CNT_W'(MAX_BLOCKS))
            state_nxt = S_SPLIT;
          else state_nxt = S_DONE;
        end else if (kind_r == KIND_FREE && pay_addr == addr_r) state_nxt = S_MCHK;
        else if (scan_wrap) state_nxt = S_DONE;
      end
      S_SPLIT: if (k_r == IDX_W'(i_r + IDX_W'(1))) state_nxt = S_DONE;
      S_MCHK: begin
        if (CNT_W'(i_r) + CNT_W'(1) < count_r && free_r[IDX_W'(i_r + IDX_W'(1))])
          state_nxt = S_MSHF;
        else state_nxt = S_DONE;
      end
      S_MSHF: if (CNT_W'(k_r) + CNT_W'(1) >= count_r) state_nxt = S_MCHK;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      base_r  <= '0;
      count_r <= CNT_W'(1);
      free_r[0] <= 1'b1;
      size_r[0] <= 16'd4096;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_HEAP_BASE) base_r <= cfg_data;
            else begin
              free_r[0] <= 1'b1;
              size_r[0] <= cfg_data[15:0];
              count_r   <= CNT_W'(1);
            end
          end
          if (start) begin
            kind_r <= in_item.kind;
            req_r  <= in_item.request_size;
            addr_r <= in_item.free_address;
            i_r    <= '0;
            off_r  <= '0;
            res_r  <= '{status: ST_OK, payload_address: '0};
          end
        end
        S_SCAN: begin
          if (at_end) begin
            res_r.status <= (kind_r == KIND_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
          end else if (kind_r == KIND_ALLOC && fits) begin
            free_r[i_r] <= 1'b0;
            res_r.payload_address <= pay_addr;
            k_r <= IDX_W'(count_r);
          end else if (kind_r == KIND_FREE && pay_addr == addr_r) begin
            free_r[i_r] <= 1'b1;
          end else begin
            off_r <= off_r + 32'(HEADER_BYTES) + 32'(size_r[i_r]);
            i_r <= i_r + IDX_W'(1);
            if (scan_wrap)
              res_r.status <= (kind_r == KIND_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
          end
        end
        S_SPLIT: begin
          // move one entry up per cycle, then drop in the remainder
          if (k_r == IDX_W'(i_r + IDX_W'(1))) begin
            free_r[k_r] <= 1'b1;
            size_r[k_r] <= 16'(size_r[i_r] - req_r - 16'(HEADER_BYTES));
            size_r[i_r] <= req_r;
            count_r <= count_r + CNT_W'(1);
          end else begin
            free_r[k_r] <= free_r[IDX_W'(k_r - IDX_W'(1))];
            size_r[k_r] <= size_r[IDX_W'(k_r - IDX_W'(1))];
            k_r <= k_r - IDX_W'(1);
          end
        end
        S_MCHK: begin
          if (CNT_W'(i_r) + CNT_W'(1) < count_r && free_r[IDX_W'(i_r + IDX_W'(1))]) begin
            size_r[i_r] <= 16'(size_r[i_r] + 16'(HEADER_BYTES)
                               + size_r[IDX_W'(i_r + IDX_W'(1))]);
            k_r <= IDX_W'(i_r + IDX_W'(1));
          end
        end
        S_MSHF: begin
          if (CNT_W'(k_r) + CNT_W'(1) < count_r) begin
            free_r[k_r] <= free_r[IDX_W'(k_r + IDX_W'(1))];
            size_r[k_r] <= size_r[IDX_W'(k_r + IDX_W'(1))];
            k_r <= k_r + IDX_W'(1);
          end else begin
            free_r[last_idx] <= 1'b0;
            count_r <= count_r - CNT_W'(1);
          end
        end
        S_DONE: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
